// ===== src/ispc_pkg.sv =====
// Shared constants, types and helper functions of the incremental speed PI controller.
package ispc_pkg;

	localparam int MOTOR_COUNT_DEF = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_BASE    = 3'd0,
		REG_KI_LIMIT   = 3'd1,
		REG_KD_GAIN    = 3'd2,
		REG_KT_DIVISOR = 3'd3,
		REG_KP_CAP     = 3'd4,
		REG_KI_SLOPE   = 3'd5,
		REG_SPEED_HIGH = 3'd6,
		REG_SPEED_LOW  = 3'd7
	} cfg_reg_t;

	localparam logic [11:0]        KP_BASE_RST    = 12'd1382;
	localparam logic [11:0]        KI_LIMIT_RST   = 12'd179;
	localparam logic signed [12:0] KD_GAIN_RST    = 13'sd0;
	localparam logic [15:0]        KT_DIVISOR_RST = 16'd170;
	localparam logic [11:0]        KP_CAP_RST     = 12'd2483;
	localparam logic [15:0]        KI_SLOPE_RST   = 16'd197;
	localparam logic signed [15:0] SPEED_HIGH_RST = 16'sh7FFF;
	localparam logic signed [15:0] SPEED_LOW_RST  = 16'sh8000;

	typedef struct packed {
		logic [11:0]        kp_base;
		logic [11:0]        ki_limit;
		logic signed [12:0] kd_gain;
		logic [15:0]        kt_divisor;
		logic [11:0]        kp_cap;
		logic [15:0]        ki_slope;
		logic signed [15:0] speed_high_limit;
		logic signed [15:0] speed_low_limit;
	} cfg_t;

	// Field and datapath widths.
	localparam int SPD_W   = 16;
	localparam int ERR_W   = 17;
	localparam int MAG_W   = 16;
	localparam int DE_W    = 18;
	localparam int DDE_W   = 19;
	localparam int ACC_W   = 32;
	localparam int INT_W   = 7;
	localparam int MUL_W   = 21;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int NUM_W   = 34;
	localparam int DEN_W   = 23;
	localparam int QUOT_W  = 13;
	localparam int CNT_W   = $clog2(QUOT_W);
	localparam int QM_W    = 13;
	localparam int GAIN_W  = 20;
	localparam int KP_W    = 12;
	localparam int SUM_W   = 34;
	localparam int Y_W     = SUM_W - 8;

	// Algorithm constants.
	localparam int RECIP10       = 52429;  // ceil(2^19 / 10)
	localparam int RECIP10_SHIFT = 19;
	localparam int KT_SCALE      = 100;
	localparam int SEP_BAND      = 350;
	localparam int INT_CAP       = 60;
	localparam int INC_CAP       = 360;
	localparam int BRAKE_VALUE   = -1000;

	typedef enum logic [2:0] {
		MUL_NONE  = 3'd0,
		MUL_RECIP = 3'd1,
		MUL_QSQ   = 3'd2,
		MUL_GAIN  = 3'd3,
		MUL_INTEG = 3'd4,
		MUL_KP    = 3'd5,
		MUL_KD    = 3'd6
	} mul_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    load_err;
		logic    load_diff;
		mul_op_t mul_op;
		logic    load_num;
		logic    load_gcap;
		logic    load_ip;
		logic    div_step;
		logic    load_kp;
		logic    sum_init;
		logic    sum_add;
		logic    load_inc;
		logic    load_acc;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_start;
		logic out_free;
		logic div_ovf;
	} status_t;

	// True when a value of the given sign must be forced to zero because the
	// measured speed is beyond one of the encoder limits.
	function automatic logic limit_kill(input logic signed [SPD_W-1:0] spd,
			input logic signed [SPD_W-1:0] hi, input logic signed [SPD_W-1:0] lo,
			input logic is_neg, input logic is_pos);
		logic kill;
		kill = 1'b0;
		if (spd > hi) begin
			kill = !is_neg;
		end else if (spd < lo) begin
			kill = !is_pos;
		end
		return kill;
	endfunction

endpackage

// ===== src/ispc_ifs.sv =====
// Request and response channel interfaces of the incremental speed PI controller.
interface ispc_req_if import ispc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    motor_select;
	logic signed [SPD_W-1:0] measured_speed;
	logic signed [SPD_W-1:0] target_speed;
	logic                    curve_mode;
	logic                    start_line;

	modport source (output valid, output motor_select, output measured_speed,
		output target_speed, output curve_mode, output start_line, input ready);
	modport sink (input valid, input motor_select, input measured_speed,
		input target_speed, input curve_mode, input start_line, output ready);
endinterface

interface ispc_rsp_if import ispc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] drive_value;
	logic signed [INT_W-1:0] integral_term;

	modport source (output valid, output drive_value, output integral_term, input ready);
	modport sink (input valid, input drive_value, input integral_term, output ready);
endinterface

// ===== src/ispc_cfg.sv =====
// Configuration register file of the incremental speed PI controller.
module ispc_cfg import ispc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_base          <= KP_BASE_RST;
			cfg_q.ki_limit         <= KI_LIMIT_RST;
			cfg_q.kd_gain          <= KD_GAIN_RST;
			cfg_q.kt_divisor       <= KT_DIVISOR_RST;
			cfg_q.kp_cap           <= KP_CAP_RST;
			cfg_q.ki_slope         <= KI_SLOPE_RST;
			cfg_q.speed_high_limit <= SPEED_HIGH_RST;
			cfg_q.speed_low_limit  <= SPEED_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_KP_BASE:    cfg_q.kp_base          <= cfg_data[11:0];
				REG_KI_LIMIT:   cfg_q.ki_limit         <= cfg_data[11:0];
				REG_KD_GAIN:    cfg_q.kd_gain          <= $signed(cfg_data[12:0]);
				REG_KT_DIVISOR: cfg_q.kt_divisor       <= cfg_data;
				REG_KP_CAP:     cfg_q.kp_cap           <= cfg_data[11:0];
				REG_KI_SLOPE:   cfg_q.ki_slope         <= cfg_data;
				REG_SPEED_HIGH: cfg_q.speed_high_limit <= $signed(cfg_data);
				REG_SPEED_LOW:  cfg_q.speed_low_limit  <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/ispc_ctrl.sv =====
// Sequencing state machine of the incremental speed PI controller.
module ispc_ctrl import ispc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [15:0] {
		ST_IDLE = 16'b0000000000000001,
		ST_ERR  = 16'b0000000000000010,
		ST_QMUL = 16'b0000000000000100,
		ST_QSQ  = 16'b0000000000001000,
		ST_GMUL = 16'b0000000000010000,
		ST_GCAP = 16'b0000000000100000,
		ST_IMUL = 16'b0000000001000000,
		ST_IP   = 16'b0000000010000000,
		ST_DIV  = 16'b0000000100000000,
		ST_KP   = 16'b0000001000000000,
		ST_PMUL = 16'b0000010000000000,
		ST_DMUL = 16'b0000100000000000,
		ST_SUM  = 16'b0001000000000000,
		ST_INC  = 16'b0010000000000000,
		ST_ACC  = 16'b0100000000000000,
		ST_OUT  = 16'b1000000000000000
	} state_t;

	state_t           state_q;
	state_t           state_nx;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.in_valid) begin
					state_nx = status.in_start ? ST_OUT : ST_ERR;
				end
			end
			ST_ERR:  state_nx = ST_QMUL;
			ST_QMUL: state_nx = ST_QSQ;
			ST_QSQ:  state_nx = ST_GMUL;
			ST_GMUL: state_nx = ST_GCAP;
			ST_GCAP: state_nx = ST_IMUL;
			ST_IMUL: state_nx = ST_IP;
			ST_IP:   state_nx = ST_DIV;
			ST_DIV: begin
				if (status.div_ovf || cnt_q == '0) begin
					state_nx = ST_KP;
				end
			end
			ST_KP:   state_nx = ST_PMUL;
			ST_PMUL: state_nx = ST_DMUL;
			ST_DMUL: state_nx = ST_SUM;
			ST_SUM:  state_nx = ST_INC;
			ST_INC:  state_nx = ST_ACC;
			ST_ACC:  state_nx = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IP) begin
				cnt_q <= CNT_W'(QUOT_W - 1);
			end else if (state_q == ST_DIV && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = MUL_NONE;
		case (state_q)
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_ERR:  cmd.load_err = 1'b1;
			ST_QMUL: begin
				cmd.mul_op    = MUL_RECIP;
				cmd.load_diff = 1'b1;
			end
			ST_QSQ:  cmd.mul_op = MUL_QSQ;
			ST_GMUL: begin
				cmd.mul_op   = MUL_GAIN;
				cmd.load_num = 1'b1;
			end
			ST_GCAP: cmd.load_gcap = 1'b1;
			ST_IMUL: cmd.mul_op = MUL_INTEG;
			ST_IP:   cmd.load_ip = 1'b1;
			ST_DIV:  cmd.div_step = !status.div_ovf;
			ST_KP:   cmd.load_kp = 1'b1;
			ST_PMUL: begin
				cmd.mul_op   = MUL_KP;
				cmd.sum_init = 1'b1;
			end
			ST_DMUL: begin
				cmd.mul_op  = MUL_KD;
				cmd.sum_add = 1'b1;
			end
			ST_SUM:  cmd.sum_add = 1'b1;
			ST_INC:  cmd.load_inc = 1'b1;
			ST_ACC:  cmd.load_acc = 1'b1;
			ST_OUT:  cmd.load_out = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ===== src/ispc_dp.sv =====
// Datapath of the incremental speed PI controller: shared multiplier, serial divider, state.
module ispc_dp import ispc_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ispc_req_if.sink          req,
	ispc_rsp_if.source        rsp,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output status_t           status
);

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	// Per-motor state.
	logic signed [ERR_W-1:0] last_err_q [MOTOR_COUNT];
	logic signed [ERR_W-1:0] prev_err_q [MOTOR_COUNT];
	logic signed [ACC_W-1:0] acc_mem_q  [MOTOR_COUNT];

	// Captured request.
	logic [MIDX_W-1:0]       midx_q;
	logic signed [SPD_W-1:0] spd_q;
	logic signed [SPD_W-1:0] tgt_q;
	logic                    curve_q;

	// Working registers.
	logic signed [ERR_W-1:0]  e_q;
	logic [MAG_W-1:0]         mag_q;
	logic signed [ERR_W-1:0]  le_q;
	logic signed [ERR_W-1:0]  pe_q;
	logic signed [ACC_W-1:0]  acc_old_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [DE_W-1:0]   de_q;
	logic signed [DDE_W-1:0]  dde_q;
	logic signed [PROD_W-1:0] p_q;
	logic [NUM_W-1:0]         num_q;
	logic [GAIN_W-1:0]        g_q;
	logic                     ovf_q;
	logic [NUM_W-1:0]         rem_q;
	logic [NUM_W:0]           dsh_q;
	logic [QUOT_W-1:0]        quot_q;
	logic signed [INT_W-1:0]  ip_q;
	logic [KP_W-1:0]          kp_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [Y_W-1:0]    y_q;
	logic signed [ACC_W-1:0]  res_drive_q;
	logic signed [INT_W-1:0]  res_int_q;
	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  out_drive_q;
	logic signed [INT_W-1:0]  out_int_q;

	logic                     accept;
	logic signed [ERR_W-1:0]  e_nx;
	logic [MAG_W-1:0]         mag_nx;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [QM_W-1:0]          q_mag;
	logic [GAIN_W-1:0]        gain_cap;
	logic [PROD_W-17:0]       f_mag;
	logic [5:0]               ip_mag;
	logic signed [INT_W-1:0]  ip_s;
	logic [QUOT_W:0]          kp_sum;
	logic signed [SUM_W-1:0]  sum_rnd;
	logic signed [Y_W-1:0]    y_raw;
	logic signed [Y_W-1:0]    y_clip;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_new;

	assign accept = req.valid && cmd.in_ready;
	assign req.ready = cmd.in_ready;

	assign status.in_valid = req.valid;
	assign status.in_start = req.start_line;
	assign status.out_free = !out_valid_q || rsp.ready;
	assign status.div_ovf  = ovf_q;

	assign rsp.valid         = out_valid_q;
	assign rsp.drive_value   = out_drive_q;
	assign rsp.integral_term = out_int_q;

	// Error and its magnitude.
	assign e_nx   = ERR_W'(tgt_q) - ERR_W'(spd_q);
	assign mag_nx = e_nx[ERR_W-1] ? MAG_W'(-e_nx) : MAG_W'(e_nx);

	// Shared multiplier operand selection.
	assign q_mag = p_q[RECIP10_SHIFT +: QM_W];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_RECIP: begin
				mul_a = MUL_W'($signed({1'b0, mag_q}));
				mul_b = MUL_W'(RECIP10);
			end
			MUL_QSQ: begin
				mul_a = MUL_W'($signed({1'b0, q_mag}));
				mul_b = MUL_W'($signed({1'b0, q_mag}));
			end
			MUL_GAIN: begin
				mul_a = MUL_W'($signed({1'b0, cfg.ki_slope}));
				mul_b = MUL_W'($signed({1'b0, mag_q}));
			end
			MUL_INTEG: begin
				mul_a = MUL_W'($signed({1'b0, g_q}));
				mul_b = MUL_W'($signed({1'b0, mag_q}));
			end
			MUL_KP: begin
				mul_a = MUL_W'($signed({1'b0, kp_q}));
				mul_b = MUL_W'(de_q);
			end
			MUL_KD: begin
				mul_a = MUL_W'(cfg.kd_gain);
				mul_b = MUL_W'(dde_q);
			end
			default: begin
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Integral part from g * |e|, truncated toward zero, clamped and gated.
	assign gain_cap = {cfg.ki_limit, 8'b0};
	assign f_mag    = $unsigned(p_q[PROD_W-1:16]);

	always_comb begin
		if (mag_q > MAG_W'(SEP_BAND)) begin
			ip_mag = '0;
		end else if (f_mag > (PROD_W-16)'(INT_CAP)) begin
			ip_mag = 6'(INT_CAP);
		end else begin
			ip_mag = f_mag[5:0];
		end
		ip_s = e_q[ERR_W-1] ? -$signed({1'b0, ip_mag}) : $signed({1'b0, ip_mag});
	end

	assign kp_sum = (QUOT_W+1)'(quot_q) + (QUOT_W+1)'(cfg.kp_base);

	// Increment: sum in Q26.8 truncated toward zero, then the curve-mode clamp and speed-limit gate.
	assign sum_rnd = sum_q + (sum_q[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
	assign y_raw   = sum_rnd[SUM_W-1:8];

	always_comb begin
		y_clip = y_raw;
		if (curve_q) begin
			if (y_raw > Y_W'(INC_CAP)) begin
				y_clip = Y_W'(INC_CAP);
			end else if (y_raw < -Y_W'(INC_CAP)) begin
				y_clip = -Y_W'(INC_CAP);
			end
			if (limit_kill(spd_q, cfg.speed_high_limit, cfg.speed_low_limit,
					y_clip[Y_W-1], !y_clip[Y_W-1] && (y_clip != '0))) begin
				y_clip = '0;
			end
		end
	end

	// Saturating accumulator update.
	assign acc_sum = (ACC_W+1)'(acc_old_q) + (ACC_W+1)'(y_q);
	assign acc_new = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
		(acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		acc_sum[ACC_W-1:0];

	// Control state: per-motor memory and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_err_q[i] <= '0;
				prev_err_q[i] <= '0;
				acc_mem_q[i]  <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_acc) begin
				acc_mem_q[midx_q]  <= acc_new;
				prev_err_q[midx_q] <= le_q;
				last_err_q[midx_q] <= e_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			midx_q  <= (MOTOR_COUNT > 1) ? MIDX_W'(req.motor_select) : '0;
			spd_q   <= req.measured_speed;
			tgt_q   <= req.target_speed;
			curve_q <= req.curve_mode;
			if (req.start_line) begin
				res_drive_q <= ACC_W'(BRAKE_VALUE);
				res_int_q   <= '0;
			end
		end
		if (cmd.load_err) begin
			e_q       <= e_nx;
			mag_q     <= mag_nx;
			le_q      <= last_err_q[midx_q];
			pe_q      <= prev_err_q[midx_q];
			acc_old_q <= acc_mem_q[midx_q];
			den_q     <= DEN_W'(cfg.kt_divisor) * DEN_W'(KT_SCALE);
		end
		if (cmd.load_diff) begin
			de_q  <= DE_W'(e_q) - DE_W'(le_q);
			dde_q <= DDE_W'(e_q) + DDE_W'(pe_q) - (DDE_W'(le_q) <<< 1);
		end
		if (cmd.mul_op != MUL_NONE) begin
			p_q <= prod;
		end
		if (cmd.load_num) begin
			num_q <= {p_q[NUM_W-9:0], 8'b0};
		end
		if (cmd.load_gcap) begin
			g_q    <= ($unsigned(p_q) > PROD_W'(gain_cap)) ? gain_cap : p_q[GAIN_W-1:0];
			ovf_q  <= {2'b0, num_q} >= {den_q, {QUOT_W{1'b0}}};
			rem_q  <= num_q;
			dsh_q  <= {den_q, {(QUOT_W-1){1'b0}}};
			quot_q <= '0;
		end
		if (cmd.load_ip) begin
			ip_q <= limit_kill(spd_q, cfg.speed_high_limit, cfg.speed_low_limit,
				ip_s[INT_W-1], !ip_s[INT_W-1] && (ip_s != '0)) ? '0 : ip_s;
		end
		if (cmd.div_step) begin
			if ({1'b0, rem_q} >= dsh_q) begin
				rem_q  <= NUM_W'({1'b0, rem_q} - dsh_q);
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.load_kp) begin
			kp_q <= (ovf_q || kp_sum >= (QUOT_W+1)'(cfg.kp_cap)) ? cfg.kp_cap :
				kp_sum[KP_W-1:0];
		end
		if (cmd.sum_init) begin
			sum_q <= SUM_W'($signed({ip_q, 8'b0}));
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + $signed(p_q[SUM_W-1:0]);
		end
		if (cmd.load_inc) begin
			y_q <= y_clip;
		end
		if (cmd.load_acc) begin
			res_drive_q <= acc_new;
			res_int_q   <= ip_q;
		end
		if (cmd.load_out) begin
			out_drive_q <= res_drive_q;
			out_int_q   <= res_int_q;
		end
	end

	// A computing request keeps the input closed on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !req.start_line) |=> !req.ready)
		else $error("input reopened while a request is in progress");

	// The integral term presented at the output stays inside its clamp.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.integral_term <= 7'sd60 && rsp.integral_term >= -7'sd60))
		else $error("integral term outside its clamp");

	// The divider never iterates once the quotient is known to saturate the gain.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !ovf_q)
		else $error("divider stepped with a saturated quotient");

endmodule

// ===== src/incremental_speed_pi_controller_top.sv =====
// Top level of the incremental speed PI controller for several motors.
// Each request names a motor and carries the measured and target encoder speeds,
// a curve mode flag and a start-line flag, and produces exactly one response with
// the motor's new drive accumulator and the integral part of this step. A
// computing request steps through the sequencer states in order, skipping the
// divider steps when the scheduled proportional gain is already known to reach
// its ceiling. Its length is set by the one-bit-per-cycle divider that forms the
// quadratic gain term and by the single shared 21 by 21 bit multiplier, which
// serves six products in turn. A start-line request brakes: it returns -1000
// with a zero integral part and leaves the motor state unchanged. Responses sit
// in an output register, so a finished response may wait for the consumer while
// a new request is taken; the next response is loaded only once the previous
// one has left. Configuration registers are written through the plain write
// port and should only be changed while no request is in flight.
module incremental_speed_pi_controller_top import ispc_pkg::*; #(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ispc_req_if.sink              req,
	ispc_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// Gains, divisor and speed limits.
	ispc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Sequencer that steps the datapath through one request.
	ispc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Arithmetic, per-motor state and the response register.
	ispc_dp #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

endmodule
